FILE: rtl/core/i2cbb_pkg.sv
// Shared types and constants for the bit-banged I2C master sequencer
`default_nettype none

package i2cbb_pkg;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic       REG_ACK_RETRY   = 1'b0;
    localparam logic [7:0] ACK_RETRY_RESET = 8'd20;
    localparam logic [3:0] BITS_PER_BYTE   = 4'd8;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_START = 3'd1,
        OP_WRITE = 3'd2,
        OP_READ  = 3'd3,
        OP_STOP  = 3'd4
    } op_t;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'd0,
        PH_ST_SDA_HI = 5'd1,
        PH_ST_SCL_HI = 5'd2,
        PH_ST_SDA_LO = 5'd3,
        PH_B_SCL_LO  = 5'd4,
        PH_B_DATA    = 5'd5,
        PH_B_SCL_HI  = 5'd6,
        PH_A_SCL_LO  = 5'd7,
        PH_A_SDA_HI  = 5'd8,
        PH_A_SCL_HI  = 5'd9,
        PH_A_SAMPLE  = 5'd10,
        PH_A_WAIT    = 5'd11,
        PH_A_FINISH  = 5'd12,
        PH_R_SCL_LO  = 5'd13,
        PH_R_SDA_HI  = 5'd14,
        PH_R_SCL_HI  = 5'd15,
        PH_R_SAMPLE  = 5'd16,
        PH_RA_SCL_LO = 5'd17,
        PH_RA_SDA    = 5'd18,
        PH_RA_SCL_HI = 5'd19,
        PH_P_SCL_LO  = 5'd20,
        PH_P_SDA_LO  = 5'd21,
        PH_P_SCL_HI  = 5'd22,
        PH_P_SDA_HI  = 5'd23,
        PH_E_SCL_LO  = 5'd24,
        PH_E_SDA_LO  = 5'd25,
        PH_E_SCL_HI  = 5'd26,
        PH_E_SDA_HI  = 5'd27
    } phase_t;

endpackage

`default_nettype wire

FILE: rtl/core/i2cbb_if.sv
// Request and result channel interfaces for the I2C master sequencer
`default_nettype none

interface i2cbb_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] data_byte;
    logic       ack_after_read;
    logic       sda_in;

    modport source (output valid, opcode, data_byte, ack_after_read, sda_in, input ready);
    modport sink   (input valid, opcode, data_byte, ack_after_read, sda_in, output ready);
endinterface

interface i2cbb_res_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic       ack_error;
    logic [7:0] read_byte;

    modport source (output valid, scl_level, sda_level, busy_res, done_res, ack_error,
                    read_byte, input ready);
    modport sink   (input valid, scl_level, sda_level, busy_res, done_res, ack_error,
                    read_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/i2c_bitbang_master_core.sv
// Top level: bit-banged I2C master sequencer, one bus step per request
// The result of a request is registered and valid in the cycle after it is
// accepted. One request per cycle unless an untaken result stalls; the
// sequencer state and the result register both update at the accepting edge,
// and the result register frees itself when taken, so a new request is taken
// while a result waits. Reset: asynchronous, active low; sequencer idle, SCL
// and SDA released, ack_retry_reg back to 20, no result pending.
`default_nettype none

module i2c_bitbang_master_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    i2cbb_cmd_if.sink                          cmd,
    i2cbb_res_if.source                        res,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [i2cbb_pkg::APB_AW-1:0]  paddr,
    input  wire logic [i2cbb_pkg::APB_DW-1:0]  pwdata,
    output logic      [i2cbb_pkg::APB_DW-1:0]  prdata,
    output logic                               pready
);
    import i2cbb_pkg::*;

    // config
    logic [7:0] ack_retry_reg;
    logic       cfg_hit;

    // sequencer state
    phase_t     phase_reg, phase_next, phase_eff;
    logic       addr_cmd_reg, addr_cmd_eff;
    logic [7:0] shift_reg, shift_eff, shift_next;
    logic [3:0] bcnt_reg, bcnt_eff, bcnt_next, bcnt_inc;
    logic [7:0] retry_reg, retry_eff, retry_next;
    logic       ack_mode_reg, ack_mode_eff;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;

    // step results
    logic       start_cmd;
    logic       done_next, err_next;
    logic [7:0] rdout_next;
    logic       accept;

    // result register
    logic       res_valid_reg;
    logic       res_scl_reg, res_sda_reg, res_busy_reg, res_done_reg, res_err_reg;
    logic [7:0] res_rd_reg;

    // APB
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2] == REG_ACK_RETRY);
    assign prdata  = cfg_hit ? {{(APB_DW-8){1'b0}}, ack_retry_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_retry_reg <= ACK_RETRY_RESET;
        end
        else if (psel && penable && pwrite && pready && cfg_hit)
        begin
            ack_retry_reg <= pwdata[7:0];
        end
    end

    // handshake
    assign cmd.ready = !res_valid_reg || res.ready;
    assign accept    = cmd.valid && cmd.ready;

    // command load when idle
    always_comb
    begin
        start_cmd = (phase_reg == PH_IDLE) &&
                    (cmd.opcode == OP_START || cmd.opcode == OP_WRITE ||
                     cmd.opcode == OP_READ  || cmd.opcode == OP_STOP);
        phase_eff    = phase_reg;
        addr_cmd_eff = addr_cmd_reg;
        shift_eff    = shift_reg;
        bcnt_eff     = bcnt_reg;
        retry_eff    = retry_reg;
        ack_mode_eff = ack_mode_reg;
        if (start_cmd)
        begin
            addr_cmd_eff = (cmd.opcode == OP_START);
            shift_eff    = cmd.data_byte;
            bcnt_eff     = '0;
            retry_eff    = '0;
            ack_mode_eff = cmd.ack_after_read;
            unique case (cmd.opcode)
                OP_START: phase_eff = PH_ST_SDA_HI;
                OP_WRITE: phase_eff = PH_B_SCL_LO;
                OP_READ:  phase_eff = PH_R_SCL_LO;
                default:  phase_eff = PH_P_SCL_LO;
            endcase
        end
    end

    assign bcnt_inc = bcnt_eff + 4'd1;

    // next phase
    always_comb
    begin
        phase_next = PH_IDLE;
        unique case (phase_eff)
            PH_IDLE:      phase_next = PH_IDLE;
            PH_ST_SDA_HI: phase_next = PH_ST_SCL_HI;
            PH_ST_SCL_HI: phase_next = PH_ST_SDA_LO;
            PH_ST_SDA_LO: phase_next = PH_B_SCL_LO;
            PH_B_SCL_LO:  phase_next = PH_B_DATA;
            PH_B_DATA:    phase_next = PH_B_SCL_HI;
            PH_B_SCL_HI:  phase_next = (bcnt_inc >= BITS_PER_BYTE) ? PH_A_SCL_LO : PH_B_SCL_LO;
            PH_A_SCL_LO:  phase_next = PH_A_SDA_HI;
            PH_A_SDA_HI:  phase_next = PH_A_SCL_HI;
            PH_A_SCL_HI:  phase_next = PH_A_SAMPLE;
            PH_A_SAMPLE:  phase_next = cmd.sda_in ? PH_A_WAIT : PH_A_FINISH;
            PH_A_WAIT:
            begin
                priority if (retry_eff != '0)
                    phase_next = PH_A_WAIT;
                else if (!cmd.sda_in)
                    phase_next = PH_A_FINISH;
                else if (addr_cmd_eff)
                    phase_next = PH_E_SCL_LO;
                else
                    phase_next = PH_IDLE;
            end
            PH_A_FINISH:  phase_next = PH_IDLE;
            PH_R_SCL_LO:  phase_next = PH_R_SDA_HI;
            PH_R_SDA_HI:  phase_next = PH_R_SCL_HI;
            PH_R_SCL_HI:  phase_next = PH_R_SAMPLE;
            PH_R_SAMPLE:  phase_next = (bcnt_inc >= BITS_PER_BYTE) ? PH_RA_SCL_LO : PH_R_SCL_LO;
            PH_RA_SCL_LO: phase_next = PH_RA_SDA;
            PH_RA_SDA:    phase_next = PH_RA_SCL_HI;
            PH_RA_SCL_HI: phase_next = PH_IDLE;
            PH_P_SCL_LO:  phase_next = PH_P_SDA_LO;
            PH_P_SDA_LO:  phase_next = PH_P_SCL_HI;
            PH_P_SCL_HI:  phase_next = PH_P_SDA_HI;
            PH_P_SDA_HI:  phase_next = PH_IDLE;
            PH_E_SCL_LO:  phase_next = PH_E_SDA_LO;
            PH_E_SDA_LO:  phase_next = PH_E_SCL_HI;
            PH_E_SCL_HI:  phase_next = PH_E_SDA_HI;
            PH_E_SDA_HI:  phase_next = PH_IDLE;
            default:      phase_next = PH_IDLE;
        endcase
    end

    // line drive, datapath and flags
    always_comb
    begin
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        shift_next = shift_eff;
        bcnt_next  = bcnt_eff;
        retry_next = retry_eff;
        done_next  = 1'b0;
        err_next   = 1'b0;
        rdout_next = '0;
        unique case (phase_eff)
            PH_ST_SDA_HI, PH_A_SDA_HI, PH_R_SDA_HI: sda_next = 1'b1;
            PH_ST_SDA_LO, PH_P_SDA_LO, PH_E_SDA_LO: sda_next = 1'b0;
            PH_ST_SCL_HI, PH_A_SCL_HI, PH_R_SCL_HI,
            PH_P_SCL_HI, PH_E_SCL_HI:               scl_next = 1'b1;
            PH_B_SCL_LO, PH_A_SCL_LO, PH_R_SCL_LO,
            PH_RA_SCL_LO, PH_P_SCL_LO, PH_E_SCL_LO:  scl_next = 1'b0;
            PH_B_DATA:
            begin
                sda_next   = shift_eff[7];
                shift_next = {shift_eff[6:0], 1'b0};
            end
            PH_B_SCL_HI:
            begin
                scl_next  = 1'b1;
                bcnt_next = (bcnt_inc >= BITS_PER_BYTE) ? 4'd0 : bcnt_inc;
            end
            PH_A_SAMPLE:
            begin
                if (cmd.sda_in)
                    retry_next = ack_retry_reg;
            end
            PH_A_WAIT:
            begin
                if (retry_eff != '0)
                    retry_next = retry_eff - 8'd1;
                else if (cmd.sda_in && !addr_cmd_eff)
                begin
                    done_next = 1'b1;
                    err_next  = 1'b1;
                end
            end
            PH_A_FINISH:
            begin
                scl_next  = 1'b0;
                done_next = 1'b1;
            end
            PH_R_SAMPLE:
            begin
                shift_next = {shift_eff[6:0], cmd.sda_in};
                bcnt_next  = (bcnt_inc >= BITS_PER_BYTE) ? 4'd0 : bcnt_inc;
            end
            PH_RA_SDA:    sda_next = !ack_mode_eff;
            PH_RA_SCL_HI:
            begin
                scl_next   = 1'b1;
                done_next  = 1'b1;
                rdout_next = shift_eff;
            end
            PH_P_SDA_HI:
            begin
                sda_next  = 1'b1;
                done_next = 1'b1;
            end
            PH_E_SDA_HI:
            begin
                sda_next  = 1'b1;
                done_next = 1'b1;
                err_next  = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            addr_cmd_reg <= 1'b0;
            shift_reg    <= '0;
            bcnt_reg     <= '0;
            retry_reg    <= '0;
            ack_mode_reg <= 1'b0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            addr_cmd_reg <= addr_cmd_eff;
            shift_reg    <= shift_next;
            bcnt_reg     <= bcnt_next;
            retry_reg    <= retry_next;
            ack_mode_reg <= ack_mode_eff;
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_scl_reg  <= scl_next;
            res_sda_reg  <= sda_next;
            res_busy_reg <= (phase_next != PH_IDLE);
            res_done_reg <= done_next;
            res_err_reg  <= err_next;
            res_rd_reg   <= rdout_next;
        end
    end

    assign res.valid     = res_valid_reg;
    assign res.scl_level = res_scl_reg;
    assign res.sda_level = res_sda_reg;
    assign res.busy_res  = res_busy_reg;
    assign res.done_res  = res_done_reg;
    assign res.ack_error = res_err_reg;
    assign res.read_byte = res_rd_reg;

endmodule

`default_nettype wire

FILE: rtl/core/i2cbb_checker.sv
// Port-level checks for the I2C master sequencer, bound to the top level
`default_nettype none

module i2cbb_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       cmd_valid,
    input wire logic       cmd_ready,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic       res_busy,
    input wire logic       res_done,
    input wire logic       res_err,
    input wire logic [7:0] res_rd
);

    // a waiting result stays until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // an empty result register never blocks requests
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> cmd_ready)
        else $error("request blocked with no result pending");

    // every request produces a result in the next cycle
    a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> res_valid)
        else $error("no result after accepted request");

    // a finishing step leaves the sequencer idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_done |-> !res_busy)
        else $error("done reported while still busy");

    // error and read data only on a done step
    a_flags_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_done |-> !res_err && (res_rd == 8'd0))
        else $error("error or read data outside a done step");

endmodule

bind i2c_bitbang_master_core i2cbb_checker u_i2cbb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_busy  (res.busy_res),
    .res_done  (res.done_res),
    .res_err   (res.ack_error),
    .res_rd    (res.read_byte)
);

`default_nettype wire
